>>> rtl/assert_macros.svh
// assertion macros shared by the rtl files of the exp2 block
// expects a clock named clock and a synchronous reset named reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge outside reset
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/e2fd_pkg.sv
// shared types, double constants and the 2^(j/64) table of the exp2 block
// no dependencies; the table is built at elaboration with exact integer math
`default_nettype none

package e2fd_pkg;

   // fixed results
   localparam logic [63:0] DBL_ONE      = 64'h3FF0000000000000;
   localparam logic [63:0] DBL_TINY_P0  = 64'h3FF0000008000000;
   localparam logic [63:0] DBL_TINY_P1  = 64'h3FF0000018000000;
   localparam logic [63:0] DBL_BIG      = 64'h47EFFFFFF8000000;
   localparam logic [63:0] DBL_INF      = 64'h7FF0000000000000;
   localparam logic [63:0] DBL_QNAN     = 64'h7FF8000000000000;
   localparam logic [63:0] DBL_TINY_N0  = 64'h3FEFFFFFF8000000;
   localparam logic [63:0] DBL_TINY_N1  = 64'h3FEFFFFFE8000000;
   localparam logic [63:0] DBL_HUGE_NEG = 64'h3680000000000000;
   localparam logic [63:0] DBL_ZERO     = 64'h0000000000000000;

   // input range bounds (float bit patterns)
   localparam logic [31:0] X_TINY_P_A = 32'h33b8aa3a;
   localparam logic [31:0] X_TINY_P_B = 32'h3438aa3a;
   localparam logic [31:0] X_BIG      = 32'h43000000;
   localparam logic [31:0] X_PINF     = 32'h7f800000;
   localparam logic [31:0] X_SIGN     = 32'h80000000;
   localparam logic [31:0] X_TINY_N_A = 32'hb338aa3b;
   localparam logic [31:0] X_TINY_N_B = 32'hb3b8aa3b;
   localparam logic [31:0] X_NEG_LIM  = 32'hc3160001;
   localparam logic [31:0] X_NINF     = 32'hff800000;

   // polynomial coefficients
   localparam logic [63:0] C1 = 64'h3FE62E42FEFA39EB;
   localparam logic [63:0] K1 = 64'h3FEFFFFFFFFFFFFF;
   localparam logic [63:0] C2 = 64'h3FAC6B08CB9FFA4C;
   localparam logic [63:0] K2 = 64'h3FCEBFBDFF941874;
   localparam logic [63:0] C3 = 64'h3F55F10DC8115CC9;
   localparam logic [63:0] K3 = 64'h3F83B29C23A3393C;

   // exceptional reduced argument and its replacement value
   localparam logic [63:0] R_EXC = 64'h3F805535A0000000;
   localparam logic [63:0] Y_EXC = 64'h3FF016B468000000;

   // one item between front and back
   typedef struct packed {
      logic               fixed;
      logic [63:0]        fixed_val;
      logic [63:0]        r;
      logic [5:0]         j;
      logic signed [8:0]  m;
   } item_type;

   typedef logic [63:0][63:0] tbl_type;

   // base raised to the 64th power by six squarings
   function automatic logic [3519:0] pow64(input logic [63:0] base);
      logic [3519:0] v;
      v = {3456'b0, base};
      for (int k = 0; k < 6; k++) begin
         v = v * v;
      end
      return v;
   endfunction

   // 2^(j/64) rounded to nearest double, by search on the mantissa
   function automatic tbl_type build_tbl();
      tbl_type        t;
      logic [63:0]    lo;
      logic [63:0]    hi;
      logic [63:0]    mid;
      logic [3519:0]  lim;
      for (int j = 0; j < 64; j++) begin
         lo  = 64'd1 << 52;
         hi  = 64'd1 << 53;
         lim = {3519'b0, 1'b1} << (3328 + j);
         while ((hi - lo) > 64'd1) begin
            mid = lo + ((hi - lo) >> 1);
            if (pow64(mid) < lim) begin
               lo = mid;
            end else begin
               hi = mid;
            end
         end
         lim = {3519'b0, 1'b1} << (3392 + j);
         if (pow64({lo[62:0], 1'b1}) < lim) begin
            lo = lo + 64'd1;
         end
         t[j] = {12'h3FF, lo[51:0]};
      end
      return t;
   endfunction

   localparam tbl_type EXP2_TBL = build_tbl();

endpackage

`default_nettype wire

>>> rtl/e2fd_dadd.sv
// four-stage double adder, round to nearest even, normal or zero operands
// uses nothing from the package
`default_nettype none

module e2fd_dadd (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic      [63:0] s
);

   // stage 1: order by magnitude and align the smaller operand
   logic [63:0]  big_in, sml_in;
   logic [10:0]  d_in;
   logic [5:0]   d6_in;
   logic [111:0] full_in;
   logic [55:0]  bsh_in;
   logic         s1_sign_ff, s1_sub_ff, s1_pass_ff;
   logic [10:0]  s1_exp_ff;
   logic [55:0]  s1_a_ff, s1_b_ff;
   logic [63:0]  s1_pv_ff;

   always_comb begin
      if (a[62:0] >= b[62:0]) begin
         big_in = a;
         sml_in = b;
      end else begin
         big_in = b;
         sml_in = a;
      end
      d_in    = big_in[62:52] - sml_in[62:52];
      d6_in   = (d_in > 11'd63) ? 6'd63 : d_in[5:0];
      full_in = {1'b1, sml_in[51:0], 3'b000, 56'b0} >> d6_in;
      bsh_in  = {full_in[111:57], full_in[56] | (|full_in[55:0])};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sign_ff <= big_in[63];
         s1_sub_ff  <= big_in[63] ^ sml_in[63];
         s1_pass_ff <= (sml_in[62:52] == 11'd0);
         s1_pv_ff   <= big_in;
         s1_exp_ff  <= big_in[62:52];
         s1_a_ff    <= {1'b1, big_in[51:0], 3'b000};
         s1_b_ff    <= bsh_in;
      end
   end

   // stage 2: add or subtract the aligned mantissas
   logic [56:0] sum_in;
   logic [56:0] s2_sum_ff;
   logic        s2_sign_ff, s2_pass_ff;
   logic [10:0] s2_exp_ff;
   logic [63:0] s2_pv_ff;

   assign sum_in = s1_sub_ff ? ({1'b0, s1_a_ff} - {1'b0, s1_b_ff})
                             : ({1'b0, s1_a_ff} + {1'b0, s1_b_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sum_ff  <= sum_in;
         s2_sign_ff <= s1_sign_ff;
         s2_pass_ff <= s1_pass_ff;
         s2_exp_ff  <= s1_exp_ff;
         s2_pv_ff   <= s1_pv_ff;
      end
   end

   // stage 3: leading zero count of the sum
   logic [5:0]  lz_in;
   logic [5:0]  s3_lz_ff;
   logic [56:0] s3_sum_ff;
   logic        s3_sign_ff, s3_pass_ff;
   logic [10:0] s3_exp_ff;
   logic [63:0] s3_pv_ff;

   always_comb begin
      lz_in = 6'd0;
      for (int i = 0; i <= 56; i++) begin
         if (s2_sum_ff[i]) begin
            lz_in = 6'(56 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_lz_ff   <= lz_in;
         s3_sum_ff  <= s2_sum_ff;
         s3_sign_ff <= s2_sign_ff;
         s3_pass_ff <= s2_pass_ff;
         s3_exp_ff  <= s2_exp_ff;
         s3_pv_ff   <= s2_pv_ff;
      end
   end

   // stage 4: normalize and round
   logic [56:0] norm_in;
   logic [55:0] m56_in;
   logic        inc_in;
   logic [53:0] mr_in;
   logic [12:0] e_in;
   logic [63:0] res_in;
   logic [63:0] s4_res_ff;

   always_comb begin
      norm_in = s3_sum_ff << s3_lz_ff;
      m56_in  = {norm_in[56:2], norm_in[1] | norm_in[0]};
      inc_in  = m56_in[2] & (m56_in[1] | m56_in[0] | m56_in[3]);
      mr_in   = {1'b0, m56_in[55:3]} + {53'b0, inc_in};
      e_in    = {2'b0, s3_exp_ff} + 13'd1 - {7'b0, s3_lz_ff} + {12'b0, mr_in[53]};
      if (s3_pass_ff) begin
         res_in = s3_pv_ff;
      end else if (s3_sum_ff == 57'd0) begin
         res_in = 64'd0;
      end else begin
         res_in = {s3_sign_ff, e_in[10:0], mr_in[51:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_res_ff <= res_in;
      end
   end

   assign s = s4_res_ff;

endmodule

`default_nettype wire

>>> rtl/e2fd_dmul.sv
// four-stage double multiplier, round to nearest even, normal or zero operands
// the 53x53 mantissa product is split into four partial products
`default_nettype none

module e2fd_dmul (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic      [63:0] p
);

   // stage 1: partial products
   logic [52:0] ma, mb;
   logic [53:0] s1_hh_ff;
   logic [52:0] s1_hl_ff, s1_lh_ff;
   logic [51:0] s1_ll_ff;
   logic        s1_sign_ff, s1_zero_ff;
   logic [11:0] s1_esum_ff;

   assign ma = {1'b1, a[51:0]};
   assign mb = {1'b1, b[51:0]};

   always_ff @(posedge clock) begin
      if (en) begin
         s1_hh_ff   <= ma[52:26] * mb[52:26];
         s1_hl_ff   <= ma[52:26] * mb[25:0];
         s1_lh_ff   <= ma[25:0] * mb[52:26];
         s1_ll_ff   <= ma[25:0] * mb[25:0];
         s1_sign_ff <= a[63] ^ b[63];
         s1_zero_ff <= (a[62:52] == 11'd0) || (b[62:52] == 11'd0);
         s1_esum_ff <= {1'b0, a[62:52]} + {1'b0, b[62:52]};
      end
   end

   // stage 2: sum of the partial products
   logic [105:0] prod_in;
   logic [105:0] s2_prod_ff;
   logic         s2_sign_ff, s2_zero_ff;
   logic [11:0]  s2_esum_ff;

   assign prod_in = {s1_hh_ff, 52'b0}
                  + {26'b0, ({1'b0, s1_hl_ff} + {1'b0, s1_lh_ff}), 26'b0}
                  + {54'b0, s1_ll_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         s2_prod_ff <= prod_in;
         s2_sign_ff <= s1_sign_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_esum_ff <= s1_esum_ff;
      end
   end

   // stage 3: normalize and decide the rounding increment
   logic [52:0] mant_in;
   logic        g_in, st_in, inc_in;
   logic [12:0] e_in;
   logic [52:0] s3_mant_ff;
   logic        s3_inc_ff, s3_sign_ff, s3_zero_ff;
   logic [12:0] s3_exp_ff;

   always_comb begin
      if (s2_prod_ff[105]) begin
         mant_in = s2_prod_ff[105:53];
         g_in    = s2_prod_ff[52];
         st_in   = |s2_prod_ff[51:0];
      end else begin
         mant_in = s2_prod_ff[104:52];
         g_in    = s2_prod_ff[51];
         st_in   = |s2_prod_ff[50:0];
      end
      inc_in = g_in & (st_in | mant_in[0]);
      e_in   = {1'b0, s2_esum_ff} - 13'd1023 + {12'b0, s2_prod_ff[105]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_mant_ff <= mant_in;
         s3_inc_ff  <= inc_in;
         s3_exp_ff  <= e_in;
         s3_sign_ff <= s2_sign_ff;
         s3_zero_ff <= s2_zero_ff;
      end
   end

   // stage 4: apply the increment
   logic [53:0] mr_in;
   logic [12:0] ef_in;
   logic [63:0] s4_res_ff;

   assign mr_in = {1'b0, s3_mant_ff} + {53'b0, s3_inc_ff};
   assign ef_in = s3_exp_ff + {12'b0, mr_in[53]};

   always_ff @(posedge clock) begin
      if (en) begin
         s4_res_ff <= s3_zero_ff ? 64'd0 : {s3_sign_ff, ef_in[10:0], mr_in[51:0]};
      end
   end

   assign p = s4_res_ff;

endmodule

`default_nettype wire

>>> rtl/e2fd_front.sv
// front part: accepts arguments, sorts out special ranges, reduces the rest
// depends on e2fd_pkg for constants and the item type
`default_nettype none

module e2fd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [31:0]        req_x_bits,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output e2fd_pkg::item_type      out_item
);

   import e2fd_pkg::*;

   logic en;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;

   // whole front stalls only when its last item cannot enter the queue
   assign en        = !s3_valid_ff || out_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: classify and place x*64 on a fixed point grid of 2^-41
   logic        fix_in;
   logic [63:0] fval_in;
   logic [4:0]  sh_in;
   logic [54:0] x_in;
   logic        s1_fix_ff, s1_sgn_ff;
   logic [63:0] s1_fval_ff;
   logic [54:0] s1_x_ff;

   always_comb begin
      fix_in  = 1'b1;
      fval_in = DBL_ZERO;
      if (req_x_bits[30:0] == 31'd0) begin
         fval_in = DBL_ONE;
      end else if (req_x_bits <= X_TINY_P_B) begin
         fval_in = (req_x_bits <= X_TINY_P_A) ? DBL_TINY_P0 : DBL_TINY_P1;
      end else if (req_x_bits >= X_BIG && req_x_bits <= X_TINY_N_B) begin
         if (req_x_bits < X_SIGN) begin
            if (req_x_bits < X_PINF) begin
               fval_in = DBL_BIG;
            end else if (req_x_bits == X_PINF) begin
               fval_in = DBL_INF;
            end else begin
               fval_in = DBL_QNAN;
            end
         end else begin
            fval_in = (req_x_bits <= X_TINY_N_A) ? DBL_TINY_N0 : DBL_TINY_N1;
         end
      end else if (req_x_bits >= X_NEG_LIM) begin
         if (req_x_bits == X_NINF) begin
            fval_in = DBL_ZERO;
         end else if (req_x_bits < X_NINF) begin
            fval_in = DBL_HUGE_NEG;
         end else begin
            fval_in = DBL_QNAN;
         end
      end else begin
         fix_in = 1'b0;
      end
      sh_in = 5'(req_x_bits[30:23] - 8'd103);
      x_in  = {31'b0, 1'b1, req_x_bits[22:0]} << sh_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_fix_ff  <= fix_in;
         s1_fval_ff <= fval_in;
         s1_sgn_ff  <= req_x_bits[31];
         s1_x_ff    <= x_in;
      end
   end

   // stage 2: truncated index n, its split into j and m, leading bit of the fraction
   logic [14:0] n_in;
   logic [5:0]  p_in;
   logic        s2_fix_ff, s2_sgn_ff;
   logic [63:0] s2_fval_ff;
   logic [40:0] s2_f_ff;
   logic [5:0]  s2_p_ff;
   logic [5:0]  s2_j_ff;
   logic [8:0]  s2_m_ff;

   always_comb begin
      n_in = s1_sgn_ff ? (15'd0 - {1'b0, s1_x_ff[54:41]}) : {1'b0, s1_x_ff[54:41]};
      p_in = 6'd0;
      for (int i = 0; i < 41; i++) begin
         if (s1_x_ff[i]) begin
            p_in = 6'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_fix_ff  <= s1_fix_ff;
         s2_fval_ff <= s1_fval_ff;
         s2_sgn_ff  <= s1_sgn_ff;
         s2_f_ff    <= s1_x_ff[40:0];
         s2_p_ff    <= p_in;
         s2_j_ff    <= n_in[5:0];
         s2_m_ff    <= n_in[14:6];
      end
   end

   // stage 3: reduced argument as a double (exact)
   logic [92:0] al_in;
   logic [63:0] r_in;
   item_type    s3_item_ff;

   always_comb begin
      al_in = {s2_f_ff, 52'b0} >> s2_p_ff;
      if (s2_f_ff == 41'd0) begin
         r_in = 64'd0;
      end else begin
         r_in = {s2_sgn_ff, 11'd976 + {5'b0, s2_p_ff}, al_in[51:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_item_ff.fixed     <= s2_fix_ff;
         s3_item_ff.fixed_val <= s2_fval_ff;
         s3_item_ff.r         <= r_in;
         s3_item_ff.j         <= s2_j_ff;
         s3_item_ff.m         <= s2_m_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

`default_nettype wire

>>> rtl/e2fd_back.sv
// back part: degree-5 polynomial, table scale and final product, fully pipelined
// depends on e2fd_pkg, e2fd_dmul and e2fd_dadd
`default_nettype none
`include "assert_macros.svh"

module e2fd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire e2fd_pkg::item_type in_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [63:0]             rsp_result_bits
);

   import e2fd_pkg::*;

   localparam int UNIT_LAT = 4;
   localparam int PIPE_LAT = 6 * UNIT_LAT;
   localparam int SCL_LAT  = 5 * UNIT_LAT;

   logic en;
   logic pop;
   logic out_valid_ff;

   // the whole back pipeline moves unless the result register is blocked
   assign en       = !out_valid_ff || rsp_ready;
   assign in_ready = en;
   assign pop      = en && in_valid;

   // entry stage: table scale, grid point and exceptional argument checks
   logic [63:0] mexp_in;
   logic        s0_valid_ff;
   logic [63:0] s0_r_ff, s0_scale_ff, s0_fval_ff;
   logic        s0_fix_ff, s0_exc_ff;

   assign mexp_in = {{3{in_item.m[8]}}, in_item.m, 52'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_r_ff     <= in_item.r;
         s0_scale_ff <= EXP2_TBL[in_item.j] + mexp_in;
         s0_exc_ff   <= (in_item.r == R_EXC);
         if (in_item.fixed) begin
            s0_fix_ff  <= 1'b1;
            s0_fval_ff <= in_item.fixed_val;
         end else begin
            s0_fix_ff  <= (in_item.r == 64'd0) && (in_item.j == 6'd0);
            s0_fval_ff <= DBL_ONE + mexp_in;
         end
      end
   end

   // delay line registers for operands that skip one or more units
   logic [63:0] r2_dl_ff     [UNIT_LAT];
   logic [63:0] t1_dl_ff     [UNIT_LAT];
   logic [63:0] v_prod_dl_ff [UNIT_LAT];
   logic [63:0] scale_dl_ff  [SCL_LAT];
   logic        exc_dl_ff    [SCL_LAT];
   logic [63:0] fval_dl_ff   [PIPE_LAT];
   logic        fix_dl_ff    [PIPE_LAT];
   logic [PIPE_LAT-1:0] vld_ff;

   // level 1: r*r and r times each odd coefficient
   logic [63:0] r2, q1, q2, q3;
   e2fd_dmul u_m_r2 (.clock, .en, .a(s0_r_ff), .b(s0_r_ff), .p(r2));
   e2fd_dmul u_m_q1 (.clock, .en, .a(s0_r_ff), .b(C1), .p(q1));
   e2fd_dmul u_m_q2 (.clock, .en, .a(s0_r_ff), .b(C2), .p(q2));
   e2fd_dmul u_m_q3 (.clock, .en, .a(s0_r_ff), .b(C3), .p(q3));

   // level 2: r^4 and the three linear terms
   logic [63:0] r4, t1, t2, t3;
   e2fd_dmul u_m_r4 (.clock, .en, .a(r2), .b(r2), .p(r4));
   e2fd_dadd u_a_t1 (.clock, .en, .a(q1), .b(K1), .s(t1));
   e2fd_dadd u_a_t2 (.clock, .en, .a(q2), .b(K2), .s(t2));
   e2fd_dadd u_a_t3 (.clock, .en, .a(q3), .b(K3), .s(t3));

   // level 3: r^2*t2 and r^4*t3
   logic [63:0] u_prod, v_prod;
   e2fd_dmul u_m_u (.clock, .en, .a(r2_dl_ff[UNIT_LAT-1]), .b(t2), .p(u_prod));
   e2fd_dmul u_m_v (.clock, .en, .a(r4), .b(t3), .p(v_prod));

   // level 4 and 5: the two sums
   logic [63:0] t4, y;
   e2fd_dadd u_a_t4 (.clock, .en, .a(u_prod), .b(t1_dl_ff[UNIT_LAT-1]), .s(t4));
   e2fd_dadd u_a_y  (.clock, .en, .a(v_prod_dl_ff[UNIT_LAT-1]), .b(t4), .s(y));

   // level 6: scale by 2^(j/64) * 2^m
   logic [63:0] y_sel, prod;
   assign y_sel = exc_dl_ff[SCL_LAT-1] ? Y_EXC : y;
   e2fd_dmul u_m_out (.clock, .en, .a(y_sel), .b(scale_dl_ff[SCL_LAT-1]), .p(prod));

   // delay lines that keep operands in step with the units
   always_ff @(posedge clock) begin
      if (en) begin
         r2_dl_ff[0]     <= r2;
         t1_dl_ff[0]     <= t1;
         v_prod_dl_ff[0] <= v_prod;
         for (int k = 1; k < UNIT_LAT; k++) begin
            r2_dl_ff[k]     <= r2_dl_ff[k-1];
            t1_dl_ff[k]     <= t1_dl_ff[k-1];
            v_prod_dl_ff[k] <= v_prod_dl_ff[k-1];
         end
         scale_dl_ff[0] <= s0_scale_ff;
         exc_dl_ff[0]   <= s0_exc_ff;
         for (int k = 1; k < SCL_LAT; k++) begin
            scale_dl_ff[k] <= scale_dl_ff[k-1];
            exc_dl_ff[k]   <= exc_dl_ff[k-1];
         end
         fval_dl_ff[0] <= s0_fval_ff;
         fix_dl_ff[0]  <= s0_fix_ff;
         for (int k = 1; k < PIPE_LAT; k++) begin
            fval_dl_ff[k] <= fval_dl_ff[k-1];
            fix_dl_ff[k]  <= fix_dl_ff[k-1];
         end
      end
   end

   // valid bits of the items in flight
   logic [PIPE_LAT-1:0] vld_in;
   assign vld_in = {vld_ff[PIPE_LAT-2:0], s0_valid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // result register
   logic [63:0] res_in;
   logic [63:0] out_res_ff;

   assign res_in = fix_dl_ff[PIPE_LAT-1] ? fval_dl_ff[PIPE_LAT-1] : prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= vld_ff[PIPE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_res_ff <= res_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_bits = out_res_ff;

   // a stalled pipeline keeps every item where it is
   `ASSERT_NEXT(a_back_hold, !en, $stable(vld_ff) && $stable(out_valid_ff))
   // a waiting result stays put until taken
   `ASSERT_NEXT(a_back_out_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_bits))
   // an item taken from the queue enters the entry stage
   `ASSERT_NEXT(a_back_issue, pop, s0_valid_ff)

endmodule

`default_nettype wire

>>> rtl/exp2_float_to_double.sv
// top level of the exp2 block: front, item queue and back
// depends on e2fd_pkg, e2fd_front and e2fd_back
`default_nettype none
`include "assert_macros.svh"

// Computes 2^x for a single-precision bit pattern x and returns the double
// bit pattern of the result, correctly matching a chain of separately rounded
// double operations. The block takes one item per cycle while nothing stalls
// and delivers results in order; an accepted item passes 3 front stages,
// the item queue, 1 entry stage, six chained four-stage double units and
// 1 result register. Throughput is set by the fully pipelined double
// multipliers and adders of the back part. The front and the back stall on
// their own; a small queue between them absorbs front-side items while the
// result port is held.

module exp2_float_to_double #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_x_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_bits
);

   import e2fd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic     f_valid, f_ready;
   item_type f_item;
   logic     b_ready;
   logic     push, pop;

   e2fd_front u_front (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_x_bits,
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   // item queue between front and back
   item_type             q_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNT_W-1:0]     q_cnt_ff, q_cnt_in;

   assign f_ready = (q_cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign push    = f_valid && f_ready;
   assign pop     = (q_cnt_ff != '0) && b_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      q_cnt_in  = q_cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         q_cnt_in = q_cnt_ff + 1'b1;
      end else if (pop && !push) begin
         q_cnt_in = q_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= f_item;
      end
   end

   e2fd_back u_back (
      .clock,
      .reset,
      .in_valid (q_cnt_ff != '0),
      .in_ready (b_ready),
      .in_item  (q_mem_ff[rd_ptr_ff]),
      .rsp_valid,
      .rsp_ready,
      .rsp_result_bits
   );

   // queue bookkeeping
   `ASSERT_ALWAYS(a_q_bound, q_cnt_ff <= CNT_W'(QUEUE_DEPTH))
   `ASSERT_ALWAYS(a_q_no_pop_empty, !(pop && q_cnt_ff == '0))
   `ASSERT_NEXT(a_q_pop_dec, pop && !push, q_cnt_ff == $past(q_cnt_ff) - 1'b1)

endmodule

`default_nettype wire
